// ===== hw/rtl/phi4m_pkg.sv =====
// Shared constants, types and the exp(-d) table for the phi^4 site update.
package phi4m_pkg;

  localparam int SIDE_DEFAULT        = 32;
  localparam int EXP_ENTRIES_DEFAULT = 256;
  localparam int EXP_MAX             = 1024;
  localparam int EXP_IDX_W           = $clog2(EXP_MAX);

  localparam logic CFG_MASS    = 1'b0;
  localparam logic CFG_QUARTIC = 1'b1;

  localparam logic signed [15:0] MASS_RESET    = 16'sd5632;
  localparam logic [14:0]        QUARTIC_RESET = 15'd1024;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_UPDATE   = 2'd1,
    OP_READ     = 2'd2,
    OP_READ_ALT = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DV1, ST_DV2, ST_DV3, ST_DV4,
    ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_RD4, ST_RD5,
    ST_AR1, ST_AR2, ST_AR3, ST_AR4, ST_AR5,
    ST_DEC, ST_DONE
  } state_t;

  typedef logic [EXP_MAX-1:0][15:0] exp_rom_t;

  // exp(-k/16) in Q0.16, built by repeated multiply with exp(-1/16) in Q0.32
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [95:0] a;
    logic [95:0] e;
    rom = '0;
    a   = 96'(1) << 32;
    for (int k = 0; k < EXP_MAX; k++) begin
      e      = (a + 96'd32768) >> 16;
      rom[k] = (e > 96'd65535) ? 16'hFFFF : e[15:0];
      a      = (a * 96'd4034748382 + (96'(1) << 31)) >> 32;
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

// ===== hw/rtl/phi4_metropolis_site_update.sv =====
// Top level: lattice store and sequenced Metropolis site update.
//
// Usage: one input channel (in_valid/in_stall) carries op, site, write_value,
// step_offset and accept_draw. Op 0 writes a site, op 2 (and 3) reads one,
// op 1 runs one Metropolis step on the site with four periodic neighbours.
// Every transaction yields exactly one result transaction on out_valid/out_stall
// with the site value afterwards and the accepted flag.
// Config: cfg_valid/cfg_ready with cfg_index (0 mass term, 1 quartic term)
// and cfg_data; cfg_ready is always high. Write only while idle.
// Sequencing: the sequencer works on one item at a time and takes no new input
// until it is back in idle. The length of a step is set by the single-port lattice
// memory (five sequential reads per update), the constant divide that splits
// the site index into row and column (states ST_DV1 to ST_DV4), and the chain
// of registered multiplies that forms the energy change.
// Reset: rst (synchronous) returns the sequencer to idle, clears out_valid and
// restores the config registers. Lattice contents are undefined until written.
// Stall: a finished result waits in the output register; the next input is
// taken meanwhile, and that item is held before the output until it drains.
module phi4_metropolis_site_update
  import phi4m_pkg::*;
#(
  parameter int SIDE        = SIDE_DEFAULT,
  parameter int EXP_ENTRIES = EXP_ENTRIES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic [9:0]         site,
  input  logic signed [15:0] write_value,
  input  logic signed [13:0] step_offset,
  input  logic [15:0]        accept_draw,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] site_value,
  output logic               accepted,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int NSITES = SIDE * SIDE;
  localparam int AW     = $clog2(NSITES);
  localparam int SW     = $clog2(SIDE);
  localparam int RK     = 20;
  localparam int RS     = (1 << RK) / SIDE;

  state_t state, state_next;

  // config
  logic signed [15:0] mass_term;
  logic [14:0]        quartic_term;

  // latched transaction
  op_t                op_r;
  logic [9:0]         site_r;
  logic signed [15:0] write_value_r;
  logic signed [13:0] step_offset_r;
  logic [15:0]        accept_draw_r;

  // index split
  logic [9:0]    q1;
  logic [9:0]    q2;
  logic [SW-1:0] col;
  logic [SW-1:0] row;

  // lattice memory
  logic signed [15:0] mem [NSITES];
  logic signed [15:0] mem_rdata;
  logic [AW-1:0]      mem_addr;
  logic               mem_we;
  logic signed [15:0] mem_wdata;

  // arithmetic
  logic signed [15:0] c_r;
  logic signed [15:0] n_r;
  logic signed [17:0] sum_r;
  logic signed [34:0] hop_r;
  logic signed [31:0] sqc_r;
  logic signed [31:0] sqn_r;
  logic signed [47:0] mas_r;
  logic [37:0]        qc2_r;
  logic [37:0]        qn2_r;
  logic signed [63:0] t1_r;
  logic signed [53:0] qua_r;
  logic signed [63:0] d_r;

  logic signed [15:0] res_value;
  logic               res_acc;

  logic               take;
  logic               in_tab;
  logic [15:0]        tab_val;
  logic               out_load;

  // ------------------------------------------------------------ config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mass_term    <= MASS_RESET;
      quartic_term <= QUARTIC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MASS:    mass_term    <= $signed(cfg_data);
        CFG_QUARTIC: quartic_term <= cfg_data[14:0];
        default:     ;
      endcase
    end
  end

  // ------------------------------------------------------------ index split
  logic [29:0]   p1;
  logic [29:0]   p2;
  logic [9:0]    r1;
  logic [9:0]    r2;
  logic [SW-1:0] col_p, col_m, row_p, row_m;
  logic [AW-1:0] addr_c, addr_xp, addr_xm, addr_yp, addr_ym;

  assign p1 = 30'(site_r) * 30'(RS);
  assign p2 = 30'(q1) * 30'(RS);
  assign r1 = site_r - 10'(q1 * 10'(SIDE));
  assign r2 = q1 - 10'(q2 * 10'(SIDE));

  assign col_p = (col == SW'(SIDE - 1)) ? '0 : SW'(col + 1'b1);
  assign col_m = (col == '0) ? SW'(SIDE - 1) : SW'(col - 1'b1);
  assign row_p = (row == SW'(SIDE - 1)) ? '0 : SW'(row + 1'b1);
  assign row_m = (row == '0) ? SW'(SIDE - 1) : SW'(row - 1'b1);

  assign addr_c  = AW'(AW'(row)   * AW'(SIDE) + AW'(col));
  assign addr_xp = AW'(AW'(row)   * AW'(SIDE) + AW'(col_p));
  assign addr_xm = AW'(AW'(row)   * AW'(SIDE) + AW'(col_m));
  assign addr_yp = AW'(AW'(row_p) * AW'(SIDE) + AW'(col));
  assign addr_ym = AW'(AW'(row_m) * AW'(SIDE) + AW'(col));

  // ------------------------------------------------------------ memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_addr];
  end

  // ------------------------------------------------------------ decision
  assign in_tab  = d_r[63:32] < 32'(EXP_ENTRIES);
  assign tab_val = EXP_ROM[d_r[32 +: EXP_IDX_W]];
  assign take    = (d_r <= 64'sd0) || (in_tab && (accept_draw_r < tab_val));
  assign out_load = !out_valid || !out_stall;

  // ------------------------------------------------------------ next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_DV1;
      ST_DV1:  state_next = ST_DV2;
      ST_DV2:  state_next = ST_DV3;
      ST_DV3:  state_next = ST_DV4;
      ST_DV4:  state_next = ST_RD0;
      ST_RD0:  state_next = (op_r == OP_WRITE) ? ST_DONE : ST_RD1;
      ST_RD1:  state_next = (op_r == OP_UPDATE) ? ST_RD2 : ST_DONE;
      ST_RD2:  state_next = ST_RD3;
      ST_RD3:  state_next = ST_RD4;
      ST_RD4:  state_next = ST_RD5;
      ST_RD5:  state_next = ST_AR1;
      ST_AR1:  state_next = ST_AR2;
      ST_AR2:  state_next = ST_AR3;
      ST_AR3:  state_next = ST_AR4;
      ST_AR4:  state_next = ST_AR5;
      ST_AR5:  state_next = ST_DEC;
      ST_DEC:  state_next = ST_DONE;
      ST_DONE: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------ outputs
  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mem_addr  = addr_c;
    mem_wdata = write_value_r;
    case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_RD0:  mem_we = (op_r == OP_WRITE);
      ST_RD1:  mem_addr = addr_xp;
      ST_RD2:  mem_addr = addr_xm;
      ST_RD3:  mem_addr = addr_yp;
      ST_RD4:  mem_addr = addr_ym;
      ST_DEC: begin
        mem_we    = take;
        mem_wdata = n_r;
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------ control regs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------ datapath
  logic signed [16:0] prop;
  logic signed [37:0] dq;
  logic signed [31:0] dsq;
  assign prop = 17'(c_r) + 17'(step_offset_r);
  assign dsq  = sqn_r - sqc_r;
  assign dq   = $signed(qn2_r) - $signed(qc2_r);

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        op_r          <= op_t'(op);
        site_r        <= site;
        write_value_r <= write_value;
        step_offset_r <= step_offset;
        accept_draw_r <= accept_draw;
      end
      ST_DV1: q1 <= p1[29:RK];
      ST_DV2: begin
        if (r1 >= 10'(SIDE)) begin
          q1  <= q1 + 10'd1;
          col <= SW'(r1 - 10'(SIDE));
        end else begin
          col <= SW'(r1);
        end
      end
      ST_DV3: q2 <= p2[29:RK];
      ST_DV4: row <= (r2 >= 10'(SIDE)) ? SW'(r2 - 10'(SIDE)) : SW'(r2);
      ST_RD0: begin
        res_value <= write_value_r;
        res_acc   <= 1'b0;
      end
      ST_RD1: begin
        c_r       <= mem_rdata;
        res_value <= mem_rdata;
        res_acc   <= 1'b0;
        sum_r     <= '0;
      end
      ST_RD2, ST_RD3, ST_RD4, ST_RD5: sum_r <= sum_r + 18'(mem_rdata);
      ST_AR1: begin
        if (prop > 17'sd32767) begin
          n_r <= 16'sh7FFF;
        end else if (prop < -17'sd32768) begin
          n_r <= 16'sh8000;
        end else begin
          n_r <= prop[15:0];
        end
      end
      ST_AR2: begin
        hop_r <= 35'(17'(c_r) - 17'(n_r)) * 35'(sum_r);
        sqc_r <= 32'(c_r) * 32'(c_r);
        sqn_r <= 32'(n_r) * 32'(n_r);
      end
      ST_AR3: begin
        mas_r <= 48'(mass_term) * 48'(dsq);
        qc2_r <= 38'(sqc_r[30:12]) * 38'(sqc_r[30:12]);
        qn2_r <= 38'(sqn_r[30:12]) * 38'(sqn_r[30:12]);
      end
      ST_AR4: begin
        qua_r <= 54'($signed({1'b0, quartic_term})) * 54'(dq);
        t1_r  <= (64'(hop_r) <<< 12) + 64'(mas_r);
      end
      ST_AR5: d_r <= t1_r + 64'(qua_r);
      ST_DEC: begin
        res_value <= take ? n_r : c_r;
        res_acc   <= take;
      end
      ST_DONE: begin
        if (out_load) begin
          site_value <= res_value;
          accepted   <= res_acc;
        end
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------ assertions
  a_we_only_when_owned: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ((state == ST_RD0 && op_r == OP_WRITE) || (state == ST_DEC && take)))
    else $error("lattice written outside a write or accepted update");

  a_done_loads_output: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_load) |=> (out_valid && state == ST_IDLE))
    else $error("finished result did not reach the output register");

  a_downhill_accepts: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DEC && d_r <= 64'sd0) |-> take)
    else $error("non-positive energy change rejected");

  a_take_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DEC && d_r > 64'sd0 && take) |-> in_tab)
    else $error("uphill move accepted beyond table range");

endmodule
